// ===== hdl/bfsp_pkg.sv =====
package bfsp_pkg;

  localparam int NODE_IDX_W = 6;
  localparam int NODE_CNT_W = 7;
  localparam int DIST_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 2'd1;

  // one entry of the node store; finite/infinite lives in a separate flag
  typedef struct packed {
    logic [DIST_W-1:0]     cost;
    logic                  has_pred;
    logic [NODE_IDX_W-1:0] pred;
  } node_rec_t;

  typedef struct packed {
    logic                  en;
    logic [NODE_IDX_W-1:0] addr;
    node_rec_t             rec;
  } node_wr_t;

endpackage

// ===== hdl/bfsp_ifs.sv =====
interface bfsp_edge_if #(parameter int WEIGHT_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [5:0]             edge_from;
  logic [5:0]             edge_to;
  logic [WEIGHT_BITS-1:0] edge_weight;
  logic                   last_edge;

  modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
  modport sink   (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface bfsp_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  node_index;
  logic [31:0] distance;
  logic        reachable;
  logic        has_pred;
  logic [5:0]  pred_node;
  logic        negative_cycle;
  logic        last_result;

  modport source (output valid, node_index, distance, reachable, has_pred, pred_node,
                  negative_cycle, last_result, input ready);
  modport sink   (input valid, node_index, distance, reachable, has_pred, pred_node,
                  negative_cycle, last_result, output ready);
endinterface

interface bfsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bfsp_edge_mem.sv =====
module bfsp_edge_mem #(
  parameter int DEPTH       = 256,
  parameter int WEIGHT_BITS = 16,
  parameter int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [5:0]             wfrom,
  input  logic [5:0]             wto,
  input  logic [WEIGHT_BITS-1:0] wweight,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [5:0]             rfrom,
  output logic [5:0]             rto,
  output logic [WEIGHT_BITS-1:0] rweight
);

  localparam int EW = 12 + WEIGHT_BITS;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wfrom, wto, wweight};
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rfrom   = rdata_r[EW-1 -: 6];
  assign rto     = rdata_r[EW-7 -: 6];
  assign rweight = rdata_r[WEIGHT_BITS-1:0];

endmodule

// ===== hdl/bfsp_node_mem.sv =====
module bfsp_node_mem #(
  parameter int MAX_NODES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  bfsp_pkg::node_wr_t   wr,
  input  logic                 re,
  input  logic [5:0]           ra,
  input  logic [5:0]           rb,
  output bfsp_pkg::node_rec_t  rd_a,
  output bfsp_pkg::node_rec_t  rd_b,
  output logic                 fin_a,
  output logic                 fin_b
);
  import bfsp_pkg::*;

  localparam int NW = $clog2(MAX_NODES);

  node_rec_t            mem [MAX_NODES];
  logic [MAX_NODES-1:0] fin_r;   // entry finite (written this run)
  node_rec_t            rd_a_r, rd_b_r;
  logic                 fin_a_r, fin_b_r;

  // finite flags: cleared at once on a run start
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      fin_r <= '0;
    end else if (wr.en) begin
      fin_r[wr.addr[NW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[NW-1:0]] <= wr.rec;
    end
    if (re) begin
      rd_a_r  <= mem[ra[NW-1:0]];
      rd_b_r  <= mem[rb[NW-1:0]];
      fin_a_r <= fin_r[ra[NW-1:0]];
      fin_b_r <= fin_r[rb[NW-1:0]];
    end
  end

  assign rd_a  = rd_a_r;
  assign rd_b  = rd_b_r;
  assign fin_a = fin_a_r;
  assign fin_b = fin_b_r;

endmodule

// ===== hdl/bellman_ford_shortest_paths.sv =====
// Edge load: one word per cycle, no result until the word marked last.
// Run: set-up, then for each of node_count-1 relaxation passes plus one cycle-check pass, each
// stored edge takes one edge-store read, one node-store read and one update.
// Results: per node, a node-store read, then a load into the output register; or one
// flagged word on a negative cycle. Reset: registers to node_count 1, source 0, edge count
// zero, all nodes infinite; edge store contents are not cleared.
module bellman_ford_shortest_paths #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bfsp_cfg_if.sink   cfg_wr,
  bfsp_edge_if.sink  in_edge,
  bfsp_res_if.source out_res
);
  import bfsp_pkg::*;

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);

  typedef enum logic [3:0] {
    S_IDLE,   // loading edges
    S_START,  // latch node count, clear finite flags
    S_INIT,   // source distance to zero
    S_EADDR,  // edge store read
    S_ENODE,  // node store read at both ends of the edge
    S_EVAL,   // relax / check
    S_ORD,    // node store read for result
    S_OSEND,  // hand result to output register
    S_NEG     // negative-cycle word
  } state_t;

  state_t                state_r, state_nxt;
  logic [NODE_CNT_W-1:0] node_count_r, node_count_nxt;
  logic [NODE_IDX_W-1:0] source_r, source_nxt;
  logic [CW-1:0]         edge_cnt_r, edge_cnt_nxt;
  logic [NODE_CNT_W-1:0] n_r, n_nxt;       // effective node count of this run
  logic [NODE_CNT_W-1:0] pass_r, pass_nxt;
  logic [AW-1:0]         k_r, k_nxt;       // edge walk
  logic                  chk_r, chk_nxt;   // cycle-check pass
  logic [NODE_IDX_W-1:0] idx_r, idx_nxt;   // result walk

  logic                  out_valid_r, out_valid_nxt;
  logic [5:0]            o_node_r, o_node_nxt;
  logic [31:0]           o_dist_r, o_dist_nxt;
  logic                  o_reach_r, o_reach_nxt;
  logic                  o_hasp_r, o_hasp_nxt;
  logic [5:0]            o_pred_r, o_pred_nxt;
  logic                  o_neg_r, o_neg_nxt;
  logic                  o_last_r, o_last_nxt;

  // edge store
  logic                   em_we, em_re;
  logic [5:0]             e_from, e_to;
  logic [WEIGHT_BITS-1:0] e_w;
  logic                   in_acc;

  // node store
  logic      nm_clr, nm_re;
  node_wr_t  nm_wr;
  logic [5:0] nm_ra;
  node_rec_t rd_a, rd_b;
  logic      fin_a, fin_b;

  // relaxation datapath
  logic [DIST_W:0]   sum_wide;
  logic [DIST_W-1:0] sum_sat;
  logic              ends_ok, relax, last_edge_k, out_free, src_ok, last_node;
  logic [NODE_CNT_W-1:0] n_eff;

  assign in_acc        = in_edge.valid && in_edge.ready;
  assign in_edge.ready = (state_r == S_IDLE);
  assign cfg_wr.ready  = 1'b1;
  assign em_we         = in_acc && (edge_cnt_r < CW'(MAX_EDGES));
  assign em_re         = (state_r == S_EADDR);

  bfsp_edge_mem #(.DEPTH(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS), .AW(AW)) u_edge_mem (
    .clk     (clk),
    .we      (em_we),
    .waddr   (edge_cnt_r[AW-1:0]),
    .wfrom   (in_edge.edge_from),
    .wto     (in_edge.edge_to),
    .wweight (in_edge.edge_weight),
    .re      (em_re),
    .raddr   (k_r),
    .rfrom   (e_from),
    .rto     (e_to),
    .rweight (e_w)
  );

  // port A reads the edge tail during relaxation, the result node otherwise
  assign nm_ra = (state_r == S_ENODE) ? e_from : idx_r;
  assign nm_re = (state_r == S_ENODE) || (state_r == S_ORD);

  bfsp_node_mem #(.MAX_NODES(MAX_NODES)) u_node_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (nm_clr),
    .wr    (nm_wr),
    .re    (nm_re),
    .ra    (nm_ra),
    .rb    (e_to),
    .rd_a  (rd_a),
    .rd_b  (rd_b),
    .fin_a (fin_a),
    .fin_b (fin_b)
  );

  // saturating sum: tail distance plus sign-extended weight
  assign sum_wide = {rd_a.cost[DIST_W-1], rd_a.cost}
                  + {{(DIST_W + 1 - WEIGHT_BITS){e_w[WEIGHT_BITS-1]}}, e_w};
  always_comb begin
    if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
      sum_sat = sum_wide[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[DIST_W-1:0];
    end
  end

  // edges touching a node outside the run are skipped; an infinite tail never relaxes
  assign ends_ok = ({1'b0, e_from} < n_r) && ({1'b0, e_to} < n_r);
  assign relax   = ends_ok && fin_a && (!fin_b || ($signed(sum_sat) < $signed(rd_b.cost)));

  assign last_edge_k = ((CW'(k_r) + CW'(1)) == edge_cnt_r);
  assign out_free    = !out_valid_r || out_res.ready;
  assign src_ok      = ({1'b0, source_r} < n_r);
  assign last_node   = ((NODE_CNT_W'(idx_r) + NODE_CNT_W'(1)) == n_r);

  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NODE_CNT_W'(1);
    end else if (node_count_r > NODE_CNT_W'(MAX_NODES)) begin
      n_eff = NODE_CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    source_nxt     = source_r;
    edge_cnt_nxt   = edge_cnt_r;
    n_nxt          = n_r;
    pass_nxt       = pass_r;
    k_nxt          = k_r;
    chk_nxt        = chk_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    o_node_nxt     = o_node_r;
    o_dist_nxt     = o_dist_r;
    o_reach_nxt    = o_reach_r;
    o_hasp_nxt     = o_hasp_r;
    o_pred_nxt     = o_pred_r;
    o_neg_nxt      = o_neg_r;
    o_last_nxt     = o_last_r;
    nm_clr         = 1'b0;
    nm_wr          = '0;

    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_NODE_COUNT:  node_count_nxt = cfg_wr.data[NODE_CNT_W-1:0];
        CFG_SOURCE_NODE: source_nxt     = cfg_wr.data[NODE_IDX_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (em_we) begin
            edge_cnt_nxt = edge_cnt_r + CW'(1);
          end
          if (in_edge.last_edge) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        n_nxt     = n_eff;
        nm_clr    = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        nm_wr.en   = src_ok;
        nm_wr.addr = source_r;
        k_nxt      = '0;
        pass_nxt   = '0;
        idx_nxt    = '0;
        chk_nxt    = (n_r == NODE_CNT_W'(1));
        state_nxt  = (edge_cnt_r == '0) ? S_ORD : S_EADDR;
      end
      S_EADDR: state_nxt = S_ENODE;
      S_ENODE: state_nxt = S_EVAL;
      S_EVAL: begin
        if (chk_r && relax) begin
          edge_cnt_nxt = '0;
          state_nxt    = S_NEG;
        end else begin
          if (!chk_r && relax) begin
            nm_wr.en           = 1'b1;
            nm_wr.addr         = e_to;
            nm_wr.rec.cost     = sum_sat;
            nm_wr.rec.has_pred = 1'b1;
            nm_wr.rec.pred     = e_from;
          end
          state_nxt = S_EADDR;
          if (last_edge_k) begin
            k_nxt = '0;
            if (chk_r) begin
              edge_cnt_nxt = '0;
              idx_nxt      = '0;
              state_nxt    = S_ORD;
            end else begin
              pass_nxt = pass_r + NODE_CNT_W'(1);
              if (pass_r + NODE_CNT_W'(1) == n_r - NODE_CNT_W'(1)) begin
                chk_nxt = 1'b1;
              end
            end
          end else begin
            k_nxt = k_r + AW'(1);
          end
        end
      end
      S_ORD: begin
        edge_cnt_nxt = '0;
        state_nxt    = S_OSEND;
      end
      S_OSEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_node_nxt    = idx_r;
          o_dist_nxt    = fin_a ? rd_a.cost : '0;
          o_reach_nxt   = fin_a;
          o_hasp_nxt    = fin_a && rd_a.has_pred;
          o_pred_nxt    = (fin_a && rd_a.has_pred) ? rd_a.pred : '0;
          o_neg_nxt     = 1'b0;
          o_last_nxt    = last_node;
          idx_nxt       = idx_r + NODE_IDX_W'(1);
          state_nxt     = last_node ? S_IDLE : S_ORD;
        end
      end
      S_NEG: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_node_nxt    = '0;
          o_dist_nxt    = '0;
          o_reach_nxt   = 1'b0;
          o_hasp_nxt    = 1'b0;
          o_pred_nxt    = '0;
          o_neg_nxt     = 1'b1;
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_CNT_W'(1);
      source_r     <= '0;
      edge_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      source_r     <= source_nxt;
      edge_cnt_r   <= edge_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    n_r       <= n_nxt;
    pass_r    <= pass_nxt;
    k_r       <= k_nxt;
    chk_r     <= chk_nxt;
    idx_r     <= idx_nxt;
    o_node_r  <= o_node_nxt;
    o_dist_r  <= o_dist_nxt;
    o_reach_r <= o_reach_nxt;
    o_hasp_r  <= o_hasp_nxt;
    o_pred_r  <= o_pred_nxt;
    o_neg_r   <= o_neg_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.node_index     = o_node_r;
  assign out_res.distance       = o_dist_r;
  assign out_res.reachable      = o_reach_r;
  assign out_res.has_pred       = o_hasp_r;
  assign out_res.pred_node      = o_pred_r;
  assign out_res.negative_cycle = o_neg_r;
  assign out_res.last_result    = o_last_r;

  // relaxation only runs over a non-empty edge list
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EADDR) |-> (edge_cnt_r != '0))
    else $error("edge walk with empty edge store");

  // a relaxation write lands on a node inside the run
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nm_wr.en && state_r == S_EVAL) |-> ({1'b0, nm_wr.addr} < n_r))
    else $error("node write outside node count");

  // relaxation passes stop before node_count-1
  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && !chk_r) |-> (pass_r + NODE_CNT_W'(1) < n_r))
    else $error("relaxation pass count overrun");

  // a held result word does not change under back-pressure
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> (out_valid_r && $stable(o_node_r) && $stable(o_last_r)))
    else $error("output word changed while stalled");

endmodule
